>>> rtl/rch_pkg.sv
package rch_pkg;

	localparam int NUM_BINS    = 64;
	localparam int BIN_W       = $clog2(NUM_BINS);
	localparam int CHAN_W      = 8;
	localparam int COUNT_BITS  = 22;
	localparam int OUT_COUNT_W = 22;
	localparam int S_TDATA_W   = 3 * CHAN_W;
	localparam int M_TDATA_W   = ((BIN_W + OUT_COUNT_W + 7) / 8) * 8;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [BIN_W-1:0]      bin_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_READ,
		ST_SHOW
	} state_t;

	typedef struct packed {
		logic pix_accept;
		logic rd_issue;
		logic out_take;
		logic clear_all;
	} ctrl_cmd_t;

	typedef struct packed {
		logic idx_last;
	} dp_status_t;

endpackage

>>> rtl/rch_ctrl.sv
module rch_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	input  logic               m_tready,
	input  rch_pkg::dp_status_t status,
	output logic               s_tready,
	output logic               m_tvalid,
	output rch_pkg::ctrl_cmd_t  cmd
);

	rch_pkg::state_t state_q;
	rch_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rch_pkg::ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rch_pkg::ST_RUN: begin
				if (s_tvalid && s_tlast) begin
					state_d = rch_pkg::ST_FLUSH;
				end
			end
			rch_pkg::ST_FLUSH: begin
				state_d = rch_pkg::ST_READ;
			end
			rch_pkg::ST_READ: begin
				state_d = rch_pkg::ST_SHOW;
			end
			rch_pkg::ST_SHOW: begin
				if (m_tready) begin
					state_d = status.idx_last ? rch_pkg::ST_RUN : rch_pkg::ST_READ;
				end
			end
			default: begin
				state_d = rch_pkg::ST_RUN;
			end
		endcase
	end

	always_comb begin
		s_tready       = (state_q == rch_pkg::ST_RUN);
		m_tvalid       = (state_q == rch_pkg::ST_SHOW);
		cmd.pix_accept = s_tready && s_tvalid;
		cmd.rd_issue   = (state_q == rch_pkg::ST_READ);
		cmd.out_take   = m_tvalid && m_tready;
		cmd.clear_all  = m_tvalid && m_tready && status.idx_last;
	end

endmodule

>>> rtl/rch_dp.sv
module rch_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rch_pkg::ctrl_cmd_t              cmd,
	input  logic [rch_pkg::S_TDATA_W-1:0]   s_tdata,   // red, green, blue
	output rch_pkg::dp_status_t             status,
	output logic [rch_pkg::M_TDATA_W-1:0]   m_tdata,   // bin_index, bin_count, zero pad
	output logic                            m_tlast    // last_bin
);

	localparam rch_pkg::count_t COUNT_MAX = {rch_pkg::COUNT_BITS{1'b1}};
	localparam rch_pkg::bin_t   LAST_BIN  = rch_pkg::BIN_W'(rch_pkg::NUM_BINS - 1);

	rch_pkg::count_t mem [rch_pkg::NUM_BINS];
	logic [rch_pkg::NUM_BINS-1:0] vld_q;

	rch_pkg::bin_t   pix_bin;
	rch_pkg::bin_t   raddr;
	logic            ren;
	rch_pkg::count_t rdata_q;
	logic            rvld_q;

	logic            valid_s1;
	rch_pkg::bin_t   bin_s1;
	logic            hit_s1;
	rch_pkg::count_t wval_q;
	rch_pkg::bin_t   rd_idx_q;

	rch_pkg::count_t base;
	rch_pkg::count_t next_cnt;
	rch_pkg::count_t out_cnt;

	assign pix_bin = {s_tdata[rch_pkg::CHAN_W-1 -: 2],
			s_tdata[2*rch_pkg::CHAN_W-1 -: 2],
			s_tdata[3*rch_pkg::CHAN_W-1 -: 2]};
	assign raddr = cmd.rd_issue ? rd_idx_q : pix_bin;
	assign ren   = cmd.rd_issue || cmd.pix_accept;

	// A hit means the previous pixel wrote this bin on the edge that read it.
	always_comb begin
		if (hit_s1) begin
			base = wval_q;
		end else if (rvld_q) begin
			base = rdata_q;
		end else begin
			base = '0;
		end
		next_cnt = (base == COUNT_MAX) ? base : base + rch_pkg::COUNT_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem[bin_s1] <= next_cnt;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
			rvld_q  <= vld_q[raddr];
		end
		if (valid_s1) begin
			wval_q <= next_cnt;
		end
		if (cmd.pix_accept) begin
			bin_s1 <= pix_bin;
			hit_s1 <= valid_s1 && (bin_s1 == pix_bin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			valid_s1 <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			valid_s1 <= cmd.pix_accept;
			if (cmd.clear_all) begin
				vld_q <= '0;
			end else if (valid_s1) begin
				vld_q[bin_s1] <= 1'b1;
			end
			if (cmd.out_take) begin
				rd_idx_q <= rd_idx_q + rch_pkg::BIN_W'(1);
			end
		end
	end

	assign out_cnt         = rvld_q ? rdata_q : '0;
	assign status.idx_last = (rd_idx_q == LAST_BIN);
	assign m_tlast         = status.idx_last;
	assign m_tdata         = rch_pkg::M_TDATA_W'({rch_pkg::OUT_COUNT_W'(out_cnt), rd_idx_q});

endmodule

>>> rtl/rgb_color_histogram_64bin_top.sv
// Channel   Group     tdata (low bit up)                 tlast        tuser
// pixels    s_axis    red, green, blue (24 bits)         last_pixel   none
// bins      m_axis    bin_index, bin_count, pad (32)     last_bin     none
//
// A pixel is taken every cycle in the run state; the counter read-modify-write
// runs one stage behind the accept, with the previous result forwarded when a
// bin repeats. After a last pixel, a flush state lets its count land, then the
// readout takes each bin through a memory read state, then an output hold state.
// Reset clears the counters at once through per-bin valid bits; so does taking
// the final bin. Pixels are held off during readout, and an output stall holds
// the current bin until it is taken.
module rgb_color_histogram_64bin_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rch_pkg::S_TDATA_W-1:0] s_tdata,   // red, green, blue
	input  logic                          s_tlast,   // last_pixel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rch_pkg::M_TDATA_W-1:0] m_tdata,   // bin_index, bin_count, zero pad
	output logic                          m_tlast    // last_bin
);

	rch_pkg::ctrl_cmd_t  cmd;
	rch_pkg::dp_status_t status;

	rch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.status   (status),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	rch_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.status  (status),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

>>> rtl/rch_chk.sv
module rch_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rch_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Stalled output request changed.");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("Pixels accepted during readout.");

	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[rch_pkg::BIN_W-1:0] == '1)))
		else $error("Last flag does not match the final bin.");

	a_stop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("Pixel input stayed open after the last pixel.");

	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("Input did not reopen after the readout.");

endmodule

bind rgb_color_histogram_64bin_top rch_chk u_chk (.*);

>>> verif/bin_hist_checker.sv
`timescale 1ns / 1ps

module bin_hist_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [rch_pkg::S_TDATA_W-1:0] s_tdata,   // red, green, blue
	input  logic                          s_tlast,   // last_pixel
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [rch_pkg::M_TDATA_W-1:0] m_tdata,   // bin_index, bin_count, zero pad
	input  logic                          m_tlast,   // last_bin
	output int                            mismatches,
	output int                            pending
);

	typedef struct packed {
		rch_pkg::bin_t                   idx;
		logic [rch_pkg::OUT_COUNT_W-1:0] count;
		logic                            last;
	} bin_report_t;

	rch_pkg::count_t bin_tally [rch_pkg::NUM_BINS];
	bin_report_t     bin_reports_due [$];
	int              err_count;

	function automatic void tally_pixel(input logic [rch_pkg::S_TDATA_W-1:0] rgb,
			input logic frame_end);
		rch_pkg::bin_t b;
		bin_report_t   rep;
		b = {rgb[rch_pkg::CHAN_W-1 -: 2], rgb[2*rch_pkg::CHAN_W-1 -: 2],
			rgb[3*rch_pkg::CHAN_W-1 -: 2]};
		if (bin_tally[b] != {rch_pkg::COUNT_BITS{1'b1}}) begin
			bin_tally[b] = bin_tally[b] + 1'b1;
		end
		if (frame_end) begin
			for (int k = 0; k < rch_pkg::NUM_BINS; k++) begin
				rep.idx   = rch_pkg::bin_t'(k);
				rep.count = bin_tally[k][rch_pkg::OUT_COUNT_W-1:0];
				rep.last  = (k == rch_pkg::NUM_BINS - 1);
				bin_reports_due.push_back(rep);
				bin_tally[k] = '0;
			end
		end
	endfunction

	function automatic void check_bin(input bin_report_t got);
		bin_report_t want;
		if (bin_reports_due.size() == 0) begin
			err_count++;
			if (err_count <= 10) begin
				$display("Unexpected bin result: idx %0d count %0d last %0b",
					got.idx, got.count, got.last);
			end
			return;
		end
		want = bin_reports_due.pop_front();
		if (got != want) begin
			err_count++;
			if (err_count <= 10) begin
				$display({"Bin mismatch: expected idx %0d count %0d last %0b, ",
					"got idx %0d count %0d last %0b"},
					want.idx, want.count, want.last, got.idx, got.count, got.last);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_report_t got;
		if (!arst_n) begin
			foreach (bin_tally[k]) begin
				bin_tally[k] = '0;
			end
			bin_reports_due.delete();
			err_count = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.idx   = m_tdata[rch_pkg::BIN_W-1:0];
				got.count = m_tdata[rch_pkg::BIN_W +: rch_pkg::OUT_COUNT_W];
				got.last  = m_tlast;
				check_bin(got);
			end
			if (s_tvalid && s_tready) begin
				tally_pixel(s_tdata, s_tlast);
			end
			mismatches <= err_count;
			pending    <= bin_reports_due.size();
		end
	end

endmodule

>>> verif/rgb_color_histogram_64bin_top_tb.sv
`timescale 1ns / 1ps

module rgb_color_histogram_64bin_top_tb;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [rch_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                          s_tlast  = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [rch_pkg::M_TDATA_W-1:0] m_tdata;
	logic                          m_tlast;
	int                            mismatches;
	int                            pending;

	int burst_left = 4;
	int pixels_sent = 0;
	int ready_mode = 0;
	int mode_cycles = 0;
	int stall_phase = 0;

	always #5 clk = ~clk;

	rgb_color_histogram_64bin_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	bin_hist_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			ready_mode  <= 0;
			mode_cycles <= 0;
			stall_phase <= 0;
		end else begin
			if (mode_cycles == 0) begin
				ready_mode  <= $urandom_range(0, 3);
				mode_cycles <= $urandom_range(50, 300);
			end else begin
				mode_cycles <= mode_cycles - 1;
			end
			stall_phase <= (stall_phase == 2) ? 0 : stall_phase + 1;
			case (ready_mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				2: begin
					m_tready <= (stall_phase == 0);
				end
				default: begin
					m_tready <= ($urandom_range(0, 7) != 0);
				end
			endcase
		end
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic frame_end);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		s_tlast  <= frame_end;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pixels_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_frame(input int frame_len, input int flavor);
		logic [7:0] r, g, b;
		logic [7:0] palette [4];
		foreach (palette[k]) begin
			palette[k] = 8'($urandom_range(0, 255));
		end
		for (int n = 0; n < frame_len; n++) begin
			case (flavor)
				0: begin
					r = 8'($urandom_range(0, 255));
					g = 8'($urandom_range(0, 255));
					b = 8'($urandom_range(0, 255));
				end
				1: begin
					r = palette[$urandom_range(0, 1)];
					g = palette[$urandom_range(1, 2)];
					b = palette[$urandom_range(2, 3)];
				end
				default: begin
					r = palette[0] ^ 8'($urandom_range(0, 63));
					g = palette[1] ^ 8'($urandom_range(0, 63));
					b = palette[2] ^ 8'($urandom_range(0, 63));
				end
			endcase
			send_pixel(r, g, b, n == frame_len - 1);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'h3F, 8'h40, 8'h7F, 1'b0);
		send_pixel(8'h80, 8'hBF, 8'hC0, 1'b0);
		send_pixel(8'hC0, 8'h80, 8'h40, 1'b0);
		send_pixel(8'h40, 8'hC0, 8'h80, 1'b0);
		send_pixel(8'h7F, 8'h3F, 8'hBF, 1'b0);
		send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
		send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
		send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
		send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
		send_pixel(8'h3F, 8'h3F, 8'h3F, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_pixel(8'h01, 8'h02, 8'h03, 1'b0);
		send_pixel(8'h04, 8'h05, 8'h06, 1'b1);
		send_pixel(8'hC0, 8'hC0, 8'hC0, 1'b1);

		while (pixels_sent < 200) begin
			send_frame(($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40),
				$urandom_range(0, 2));
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		repeat (2) @(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS rgb_color_histogram_64bin_top");
		end else begin
			$display("FAIL rgb_color_histogram_64bin_top");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL rgb_color_histogram_64bin_top");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rch_pkg.sv
rtl/rch_ctrl.sv
rtl/rch_dp.sv
rtl/rgb_color_histogram_64bin_top.sv
rtl/rch_chk.sv
verif/bin_hist_checker.sv
verif/rgb_color_histogram_64bin_top_tb.sv
